// File: sv/ordered_dither_palette_quantizer_core_assert.svh
// assertion macros shared by the quantizer rtl
`ifndef ORDERED_DITHER_PALETTE_QUANTIZER_CORE_ASSERT_SVH
`define ORDERED_DITHER_PALETTE_QUANTIZER_CORE_ASSERT_SVH

// same-cycle implication
`define ODPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ODPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/odpq_pkg.sv
package odpq_pkg;

    localparam int CH_W   = 8;
    localparam int OFF_W  = 9;
    localparam int DITH_W = 10;
    localparam int SQ_W   = 18;
    localparam int DIST_W = 30;
    localparam int STAGES = 6;
    localparam int NCOL   = 7;

    localparam logic [1:0] REG_SPREAD_RED   = 2'd0;
    localparam logic [1:0] REG_SPREAD_GREEN = 2'd1;
    localparam logic [1:0] REG_SPREAD_BLUE  = 2'd2;

    localparam logic [CH_W-1:0] SPREAD_RED_RST   = 8'd92;
    localparam logic [CH_W-1:0] SPREAD_GREEN_RST = 8'd85;
    localparam logic [CH_W-1:0] SPREAD_BLUE_RST  = 8'd65;

    typedef enum logic [2:0] {
        COLOR_BLACK  = 3'd0,
        COLOR_WHITE  = 3'd1,
        COLOR_GREEN  = 3'd2,
        COLOR_BLUE   = 3'd3,
        COLOR_RED    = 3'd4,
        COLOR_YELLOW = 3'd5,
        COLOR_ORANGE = 3'd6
    } color_t;

    typedef logic signed [DITH_W-1:0] dith_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [DIST_W-1:0]        dist_t;

    typedef struct packed {
        dist_t  cost;
        color_t idx;
    } cand_t;

    typedef struct packed {
        logic [8:0] byte_slot;
        logic       high_nibble;
        logic       dropped;
    } side_t;

    // bayer threshold, indexed by {x[1:0], y[1:0]}
    localparam logic [3:0] BAYER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // palette levels per channel
    localparam logic [8:0] LVL_R [2] = '{9'd0, 9'd255};
    localparam logic [8:0] LVL_G [4] = '{9'd0, 9'd128, 9'd170, 9'd255};
    localparam logic [8:0] LVL_B [2] = '{9'd0, 9'd255};

    // which level each palette entry uses
    localparam logic [0:0] PAL_R_SEL [NCOL] = '{1'd0, 1'd1, 1'd0, 1'd0, 1'd1, 1'd1, 1'd1};
    localparam logic [1:0] PAL_G_SEL [NCOL] = '{2'd0, 2'd3, 2'd1, 2'd0, 2'd0, 2'd3, 2'd2};
    localparam logic [0:0] PAL_B_SEL [NCOL] = '{1'd0, 1'd1, 1'd0, 1'd1, 1'd0, 1'd0, 1'd0};

    // squared luma weights 30, 59, 11
    localparam logic [DIST_W-1:0] W_RED   = 30'd900;
    localparam logic [DIST_W-1:0] W_GREEN = 30'd3481;
    localparam logic [DIST_W-1:0] W_BLUE  = 30'd121;

    // round half away of spread * (t - 8) / 16
    function automatic logic signed [OFF_W-1:0] dither_offset(
        input logic [CH_W-1:0] spread,
        input logic [3:0]      t
    );
        logic signed [4:0]  tc;
        logic signed [13:0] prod;
        logic [13:0]        mag;
        logic [13:0]        q;
        logic [OFF_W-1:0]   qn;
        tc   = $signed({1'b0, t}) - 5'sd8;
        prod = $signed({6'b000000, spread}) * 14'(tc);
        mag  = prod[13] ? 14'(-prod) : 14'(prod);
        q    = (mag + 14'd8) >> 4;
        qn   = q[OFF_W-1:0];
        return prod[13] ? $signed(OFF_W'(-qn)) : $signed(qn);
    endfunction

    function automatic sq_t sq_diff(input logic [8:0] lvl, input dith_t d);
        logic signed [10:0] diff;
        logic signed [21:0] s;
        diff = $signed({2'b00, lvl}) - 11'(d);
        s    = diff * diff;
        return s[SQ_W-1:0];
    endfunction

    function automatic cand_t pick(input cand_t lo, input cand_t hi);
        return (hi.cost < lo.cost) ? hi : lo;
    endfunction

endpackage

// File: sv/ordered_dither_palette_quantizer_core.sv
// throughput: one word per cycle while out_stall is low,
// set by a six-stage pipeline with no shared unit
// a stalled output stage holds; bubbles are squeezed out behind it
// reset: pipeline valid bits cleared, spread registers back to 92, 85, 65
`include "ordered_dither_palette_quantizer_core_assert.svh"

module ordered_dither_palette_quantizer_core #(
    parameter int LINE_WIDTH = 600
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [9:0] pixel_x,
    input  logic [9:0] pixel_y,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] color_index,
    output logic [8:0] byte_slot,
    output logic       high_nibble,
    output logic       dropped
);
    import odpq_pkg::*;

    logic [CH_W-1:0] spread_red_reg;
    logic [CH_W-1:0] spread_green_reg;
    logic [CH_W-1:0] spread_blue_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   stage_ready;
    side_t             side_reg [STAGES];

    dith_t r1_reg, g1_reg, b1_reg;
    sq_t   sqr_reg [2];
    sq_t   sqg_reg [4];
    sq_t   sqb_reg [2];
    dist_t wr_reg [2];
    dist_t wg_reg [4];
    dist_t wb_reg [2];
    dist_t dist_reg [NCOL];
    cand_t l1_reg [4];
    color_t out_idx_reg;

    logic [3:0] thresh;
    side_t      side_in;
    cand_t      best_cand;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_red_reg   <= SPREAD_RED_RST;
            spread_green_reg <= SPREAD_GREEN_RST;
            spread_blue_reg  <= SPREAD_BLUE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SPREAD_RED:   spread_red_reg   <= cfg_data;
                REG_SPREAD_GREEN: spread_green_reg <= cfg_data;
                REG_SPREAD_BLUE:  spread_blue_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // backpressure chain
    always_comb
    begin
        stage_ready[STAGES] = !out_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign in_stall = !stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign thresh                = BAYER[{pixel_x[1:0], pixel_y[1:0]}];
    assign side_in.byte_slot     = pixel_x[9:1];
    assign side_in.high_nibble   = !pixel_x[0];
    assign side_in.dropped       = {1'b0, pixel_x} >= 11'(LINE_WIDTH);

    // position fields ride alongside
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (stage_ready[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // stage 1: dither offset
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            r1_reg <= $signed({2'b00, red})   + DITH_W'(dither_offset(spread_red_reg, thresh));
            g1_reg <= $signed({2'b00, green}) + DITH_W'(dither_offset(spread_green_reg, thresh));
            b1_reg <= $signed({2'b00, blue})  + DITH_W'(dither_offset(spread_blue_reg, thresh));
        end
    end

    // stage 2: squared differences to each palette level
    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            for (int k = 0; k < 2; k++)
            begin
                sqr_reg[k] <= sq_diff(LVL_R[k], r1_reg);
                sqb_reg[k] <= sq_diff(LVL_B[k], b1_reg);
            end
            for (int k = 0; k < 4; k++)
            begin
                sqg_reg[k] <= sq_diff(LVL_G[k], g1_reg);
            end
        end
    end

    // stage 3: luma weighting
    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            for (int k = 0; k < 2; k++)
            begin
                wr_reg[k] <= DIST_W'(sqr_reg[k]) * W_RED;
                wb_reg[k] <= DIST_W'(sqb_reg[k]) * W_BLUE;
            end
            for (int k = 0; k < 4; k++)
            begin
                wg_reg[k] <= DIST_W'(sqg_reg[k]) * W_GREEN;
            end
        end
    end

    // stage 4: distance per palette entry
    always_ff @(posedge clk)
    begin
        if (stage_ready[3])
        begin
            for (int i = 0; i < NCOL; i++)
            begin
                dist_reg[i] <= wr_reg[PAL_R_SEL[i]] + wg_reg[PAL_G_SEL[i]]
                             + wb_reg[PAL_B_SEL[i]];
            end
        end
    end

    // stage 5: first compare level, lower index wins ties
    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            l1_reg[0] <= pick('{dist_reg[0], COLOR_BLACK},  '{dist_reg[1], COLOR_WHITE});
            l1_reg[1] <= pick('{dist_reg[2], COLOR_GREEN},  '{dist_reg[3], COLOR_BLUE});
            l1_reg[2] <= pick('{dist_reg[4], COLOR_RED},    '{dist_reg[5], COLOR_YELLOW});
            l1_reg[3] <= '{dist_reg[6], COLOR_ORANGE};
        end
    end

    // stage 6: final compare
    always_comb
    begin
        best_cand = pick(pick(l1_reg[0], l1_reg[1]), pick(l1_reg[2], l1_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[5])
        begin
            out_idx_reg <= best_cand.idx;
        end
    end

    assign out_valid   = valid_reg[STAGES-1];
    assign color_index = out_idx_reg;
    assign byte_slot   = side_reg[STAGES-1].byte_slot;
    assign high_nibble = side_reg[STAGES-1].high_nibble;
    assign dropped     = side_reg[STAGES-1].dropped;

    `ODPQ_ASSERT_NOW(a_index_range, out_valid, color_index <= COLOR_ORANGE, "index out of palette")
    `ODPQ_ASSERT_NOW(a_dropped_match, out_valid, dropped == ({1'b0, byte_slot, !high_nibble} >= 11'(LINE_WIDTH)), "dropped flag disagrees with position")
    `ODPQ_ASSERT_NOW(a_stall_full, in_stall, (&valid_reg) && out_stall, "input stalled with room in pipeline")
    `ODPQ_ASSERT_NEXT(a_stage1_hold, valid_reg[0] && !stage_ready[0], $stable(r1_reg) && $stable(g1_reg) && $stable(b1_reg), "held stage lost its word")

endmodule

// File: verif/testbench.sv
module testbench;
    import odpq_pkg::*;

    localparam int LINE_WIDTH = 600;
    localparam logic [1:0] REG_NONE = 2'd3;

    localparam int DITHER_MATRIX [4][4] = '{
        '{0, 8, 2, 10},
        '{12, 4, 14, 6},
        '{3, 11, 1, 9},
        '{15, 7, 13, 5}
    };

    localparam int PALETTE [7][3] = '{
        '{0, 0, 0},
        '{255, 255, 255},
        '{0, 128, 0},
        '{0, 0, 255},
        '{255, 0, 0},
        '{255, 255, 0},
        '{255, 170, 0}
    };

    localparam int LUMA_WEIGHT [3] = '{30, 59, 11};

    typedef struct packed {
        color_t     color;
        logic [8:0] slot;
        logic       high;
        logic       drop;
    } quant_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [9:0] pixel_x = 10'd0;
    logic [9:0] pixel_y = 10'd0;
    logic [7:0] red = 8'd0;
    logic [7:0] green = 8'd0;
    logic [7:0] blue = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] color_index;
    logic [8:0] byte_slot;
    logic       high_nibble;
    logic       dropped;

    logic [7:0] spread_red = SPREAD_RED_RST;
    logic [7:0] spread_green = SPREAD_GREEN_RST;
    logic [7:0] spread_blue = SPREAD_BLUE_RST;

    quant_t quant_expected [$];
    int     mismatches = 0;
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;

    ordered_dither_palette_quantizer_core #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .color_index(color_index),
        .byte_slot(byte_slot),
        .high_nibble(high_nibble),
        .dropped(dropped)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // round half away from zero of spread * (thr - 8) / 16
    function automatic int offset_for(int spread, int thr);
        int prod;
        int mag;
        int q;
        prod = spread * (thr - 8);
        mag = (prod < 0) ? -prod : prod;
        q = (mag + 8) / 16;
        return (prod < 0) ? -q : q;
    endfunction

    function automatic quant_t quantize_pixel(logic [9:0] x, logic [9:0] y,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        quant_t res;
        int     thr;
        int     chan [3];
        longint diff;
        longint total;
        longint best;
        int     best_i;
        thr = DITHER_MATRIX[x[1:0]][y[1:0]];
        chan[0] = int'(r) + offset_for(int'(spread_red), thr);
        chan[1] = int'(g) + offset_for(int'(spread_green), thr);
        chan[2] = int'(b) + offset_for(int'(spread_blue), thr);
        best = 0;
        best_i = 0;
        for (int i = 0; i < 7; i++)
        begin
            total = 0;
            for (int c = 0; c < 3; c++)
            begin
                diff = longint'(LUMA_WEIGHT[c] * (PALETTE[i][c] - chan[c]));
                total += diff * diff;
            end
            if (i == 0 || total < best)
            begin
                best = total;
                best_i = i;
            end
        end
        res.color = color_t'(best_i);
        res.slot = x[9:1];
        res.high = ~x[0];
        res.drop = (int'(x) >= LINE_WIDTH);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        quant_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (quant_expected.size() == 0)
                report_mismatch("unexpected word", int'(color_index), 0);
            else
            begin
                want = quant_expected.pop_front();
                if (color_index !== want.color)
                    report_mismatch("color_index", int'(color_index), int'(want.color));
                if (byte_slot !== want.slot)
                    report_mismatch("byte_slot", int'(byte_slot), int'(want.slot));
                if (high_nibble !== want.high)
                    report_mismatch("high_nibble", int'(high_nibble), int'(want.high));
                if (dropped !== want.drop)
                    report_mismatch("dropped", int'(dropped), int'(want.drop));
            end
        end
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic send_pixel(logic [9:0] x, logic [9:0] y,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        quant_expected.push_back(quantize_pixel(x, y, r, g, b));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (quant_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_spread(logic [1:0] idx, logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_SPREAD_RED:   spread_red = value;
            REG_SPREAD_GREEN: spread_green = value;
            REG_SPREAD_BLUE:  spread_blue = value;
            default:          ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_spreads(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        wait_drain();
        write_spread(REG_SPREAD_RED, r);
        write_spread(REG_SPREAD_GREEN, g);
        write_spread(REG_SPREAD_BLUE, b);
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(15));
            1:       return 8'(255 - $urandom_range(15));
            2:       return 8'($urandom_range(190, 110));
            default: return 8'($urandom);
        endcase
    endfunction

    // palette colours at a zero-offset threshold, then line edges
    task automatic test_reset_spreads();
        for (int i = 0; i < 7; i++)
            send_pixel(10'(4 * i), 10'(4 * i + 1), 8'(PALETTE[i][0]), 8'(PALETTE[i][1]),
                       8'(PALETTE[i][2]));
        send_pixel(10'd598, 10'd2, 8'd200, 8'd40, 8'd10);
        send_pixel(10'd599, 10'd2, 8'd10, 8'd40, 8'd200);
        send_pixel(10'd600, 10'd3, 8'd128, 8'd128, 8'd128);
        send_pixel(10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255);
        send_pixel(10'd1, 10'd0, 8'd0, 8'd0, 8'd0);
    endtask

    // equal distance to black and green goes to black
    task automatic test_zero_spread();
        write_spreads(8'd0, 8'd0, 8'd0);
        send_pixel(10'd0, 10'd0, 8'd0, 8'd64, 8'd0);
        send_pixel(10'd5, 10'd6, 8'd128, 8'd128, 8'd128);
        send_pixel(10'd7, 10'd3, 8'd255, 8'd149, 8'd0);
    endtask

    // half-way offsets and dithered channels out of byte range
    task automatic test_full_spread();
        write_spreads(8'd255, 8'd255, 8'd255);
        send_pixel(10'd0, 10'd0, 8'd255, 8'd255, 8'd255);
        send_pixel(10'd3, 10'd0, 8'd255, 8'd255, 8'd255);
        send_pixel(10'd3, 10'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(10'd2, 10'd2, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_ignored_register();
        write_spreads(8'd17, 8'd200, 8'd3);
        write_spread(REG_NONE, 8'hFF);
        send_pixel(10'd3, 10'd0, 8'd120, 8'd120, 8'd120);
        send_pixel(10'd0, 10'd0, 8'd130, 8'd130, 8'd130);
    endtask

    task automatic test_random_stream(int count, int idle_pct, int stall_pct,
                                      logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [9:0] x;
        write_spreads(r, g, b);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(49) == 0)
                wait_drain();
            x = ($urandom_range(3) == 0) ? 10'($urandom_range(610, 590)) : 10'($urandom);
            send_pixel(x, 10'($urandom), pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    initial
    begin
        sender_idle_pct = 37;
        receiver_stall_pct = 86;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_spreads();
        test_zero_spread();
        test_full_spread();
        test_ignored_register();
        test_random_stream(200, 37, 86, 8'($urandom), 8'($urandom), 8'($urandom));
        test_random_stream(200, 86, 37, 8'd0, 8'd255, 8'd0);
        test_random_stream(200, 0, 0, SPREAD_RED_RST, SPREAD_GREEN_RST, SPREAD_BLUE_RST);
        wait_drain();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/odpq_pkg.sv
sv/ordered_dither_palette_quantizer_core.sv
verif/testbench.sv
